@@ rtl/core/panel_power_sequencer_assert.svh @@
// assertion macros for the panel power sequencer
// expects clk and rst_n in the scope of the file that includes it
`ifndef PANEL_POWER_SEQUENCER_ASSERT_SVH
`define PANEL_POWER_SEQUENCER_ASSERT_SVH

// checked only outside reset
`define PPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define PPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/pps_pkg.sv @@
// shared types and constants for the panel power sequencer
// no dependencies
package pps_pkg;

  localparam int OP_W       = 2;
  localparam int PHASE_W    = 2;
  localparam int THR_W      = 12;
  localparam int WAIT_W     = 8;
  localparam int TAG_W      = 4;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [OP_W-1:0] OP_POLL      = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK      = 2'd1;
  localparam logic [OP_W-1:0] OP_HEARTBEAT = 2'd2;
  localparam logic [OP_W-1:0] OP_DISABLE   = 2'd3;

  localparam logic [PHASE_W-1:0] PH_OFF      = 2'd0;
  localparam logic [PHASE_W-1:0] PH_LOGIC    = 2'd1;
  localparam logic [PHASE_W-1:0] PH_FULL     = 2'd2;
  localparam logic [PHASE_W-1:0] PH_DISABLED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HB_WAIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KA_WAIT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HB_TAG    = 2'd3;

  localparam logic [THR_W-1:0]  THRESHOLD_RST = 12'd100;
  localparam logic [WAIT_W-1:0] HB_WAIT_RST   = 8'd1;
  localparam logic [WAIT_W-1:0] KA_WAIT_RST   = 8'd2;
  localparam logic [TAG_W-1:0]  HB_TAG_RST    = 4'd8;

  typedef struct packed {
    logic [THR_W-1:0]  threshold;
    logic [WAIT_W-1:0] hb_wait;
    logic [WAIT_W-1:0] ka_wait;
    logic [TAG_W-1:0]  hb_tag;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               alive;
    logic               rx_armed;
  } ctrl_t;

endpackage

@@ rtl/core/pps_if.sv @@
// valid/ready channel interfaces for the panel power sequencer
// depends on pps_pkg
interface pps_in_if #(
  parameter int SAMPLE_BITS = 12
) ();
  logic                        valid;
  logic                        ready;
  logic [pps_pkg::OP_W-1:0]    opcode;
  logic [SAMPLE_BITS-1:0]      adc_sample;
  logic [pps_pkg::BYTE_W-1:0]  heartbeat_byte;

  modport source (output valid, output opcode, output adc_sample, output heartbeat_byte,
                  input ready);
  modport sink   (input valid, input opcode, input adc_sample, input heartbeat_byte,
                  output ready);
endinterface

interface pps_out_if ();
  logic                          valid;
  logic                          ready;
  logic                          rail_3v3_on;
  logic                          rail_12v_on;
  logic                          link_enabled;
  logic                          receive_armed;
  logic [pps_pkg::PHASE_W-1:0]   power_phase;
  logic                          color_send_ok;
  logic                          balance_send_ok;

  modport source (output valid, output rail_3v3_on, output rail_12v_on,
                  output link_enabled, output receive_armed, output power_phase,
                  output color_send_ok, output balance_send_ok, input ready);
  modport sink   (input valid, input rail_3v3_on, input rail_12v_on,
                  input link_enabled, input receive_armed, input power_phase,
                  input color_send_ok, input balance_send_ok, output ready);
endinterface

@@ rtl/core/pps_next.sv @@
// next-state logic of the panel power sequencer for one input word
// depends on pps_pkg
module pps_next #(
  parameter int SAMPLE_BITS = 12,
  parameter int TICK_BITS   = 8
) (
  input  logic [pps_pkg::OP_W-1:0]   opcode,
  input  logic [SAMPLE_BITS-1:0]     adc_sample,
  input  logic [pps_pkg::BYTE_W-1:0] heartbeat_byte,
  input  pps_pkg::cfg_t              cfg,
  input  pps_pkg::ctrl_t             ctrl,
  input  logic [TICK_BITS-1:0]       tick,
  output pps_pkg::ctrl_t             ctrl_nxt,
  output logic [TICK_BITS-1:0]       tick_nxt
);

  localparam int SW = (SAMPLE_BITS > pps_pkg::THR_W) ? SAMPLE_BITS : pps_pkg::THR_W;
  localparam int CW = (TICK_BITS > pps_pkg::WAIT_W) ? TICK_BITS : pps_pkg::WAIT_W;

  logic discharged;
  logic hb_due;
  logic ka_due;
  logic tag_match;

  assign discharged = SW'(adc_sample) < SW'(cfg.threshold);
  assign hb_due     = CW'(tick) > CW'(cfg.hb_wait);
  assign ka_due     = CW'(tick) > CW'(cfg.ka_wait);
  assign tag_match  = heartbeat_byte[pps_pkg::BYTE_W-1 -: pps_pkg::TAG_W] == cfg.hb_tag;

  always_comb begin
    ctrl_nxt = ctrl;
    tick_nxt = tick;
    unique case (opcode)
      pps_pkg::OP_POLL: begin
        unique case (ctrl.phase)
          pps_pkg::PH_OFF: begin
            if (discharged) begin
              ctrl_nxt.phase    = pps_pkg::PH_LOGIC;
              ctrl_nxt.rx_armed = 1'b1;
              tick_nxt          = '0;
            end
          end
          pps_pkg::PH_LOGIC, pps_pkg::PH_FULL: begin
            if ((ctrl.phase == pps_pkg::PH_LOGIC) ? hb_due : ka_due) begin
              tick_nxt       = '0;
              ctrl_nxt.alive = 1'b0;
              if (ctrl.alive) begin
                ctrl_nxt.phase = pps_pkg::PH_FULL;
              end else begin
                // heartbeat lost: drop everything
                ctrl_nxt.phase    = pps_pkg::PH_OFF;
                ctrl_nxt.rx_armed = 1'b0;
              end
            end
          end
          pps_pkg::PH_DISABLED: begin
          end
        endcase
      end
      pps_pkg::OP_TICK: begin
        if (tick != '1) begin
          tick_nxt = tick + 1'b1;
        end
      end
      pps_pkg::OP_HEARTBEAT: begin
        if (ctrl.rx_armed) begin
          ctrl_nxt.rx_armed = 1'b0;
          if (ctrl.phase != pps_pkg::PH_OFF) begin
            ctrl_nxt.rx_armed = tag_match;
            ctrl_nxt.alive    = tag_match;
          end
        end
      end
      pps_pkg::OP_DISABLE: begin
        ctrl_nxt.phase    = pps_pkg::PH_DISABLED;
        ctrl_nxt.alive    = 1'b0;
        ctrl_nxt.rx_armed = 1'b0;
        tick_nxt          = '0;
      end
    endcase
  end

endmodule

@@ rtl/core/panel_power_sequencer.sv @@
// panel power sequencer top level: config registers, state and result register
// depends on pps_pkg, pps_if, pps_next and panel_power_sequencer_assert.svh
//
//  channel | dir | handshake     | payload
//  in_ch   | in  | valid/ready   | opcode, adc_sample, heartbeat_byte
//  out_ch  | out | valid/ready   | rails, link, receive_armed, power_phase, send flags
//  cfg_*   | in  | write enable  | cfg_index, cfg_data
//
// one word per cycle while in_ch.ready is high; the next state for a word is computed
// combinationally and its result appears in the output register on the next cycle
// in_ch.ready is high while the output register is empty or being drained,
// and low while rst_n is low
// synchronous reset clears state to off and config to defaults
`include "panel_power_sequencer_assert.svh"

module panel_power_sequencer #(
  parameter int SAMPLE_BITS = 12,
  parameter int TICK_BITS   = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  pps_in_if.sink                          in_ch,
  pps_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [pps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pps_pkg::CFG_DATA_W-1:0]  cfg_data
);

  pps_pkg::cfg_t              cfg_r;
  pps_pkg::ctrl_t             ctrl_r;
  pps_pkg::ctrl_t             ctrl_nxt;
  logic [TICK_BITS-1:0]       tick_r;
  logic [TICK_BITS-1:0]       tick_nxt;
  logic                       out_valid_r;
  logic [pps_pkg::PHASE_W-1:0] out_phase_r;
  logic                       out_armed_r;
  logic                       in_fire;
  logic                       powered;
  logic                       full;

  assign in_ch.ready = rst_n && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold <= pps_pkg::THRESHOLD_RST;
      cfg_r.hb_wait   <= pps_pkg::HB_WAIT_RST;
      cfg_r.ka_wait   <= pps_pkg::KA_WAIT_RST;
      cfg_r.hb_tag    <= pps_pkg::HB_TAG_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pps_pkg::REG_THRESHOLD: cfg_r.threshold <= cfg_data[pps_pkg::THR_W-1:0];
        pps_pkg::REG_HB_WAIT:   cfg_r.hb_wait   <= cfg_data[pps_pkg::WAIT_W-1:0];
        pps_pkg::REG_KA_WAIT:   cfg_r.ka_wait   <= cfg_data[pps_pkg::WAIT_W-1:0];
        pps_pkg::REG_HB_TAG:    cfg_r.hb_tag    <= cfg_data[pps_pkg::TAG_W-1:0];
      endcase
    end
  end

  pps_next #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TICK_BITS   (TICK_BITS)
  ) u_next (
    .opcode         (in_ch.opcode),
    .adc_sample     (in_ch.adc_sample),
    .heartbeat_byte (in_ch.heartbeat_byte),
    .cfg            (cfg_r),
    .ctrl           (ctrl_r),
    .tick           (tick_r),
    .ctrl_nxt       (ctrl_nxt),
    .tick_nxt       (tick_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.phase    <= pps_pkg::PH_OFF;
      ctrl_r.alive    <= 1'b0;
      ctrl_r.rx_armed <= 1'b0;
      tick_r          <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (in_fire) begin
        ctrl_r <= ctrl_nxt;
        tick_r <= tick_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result word payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_phase_r <= ctrl_nxt.phase;
      out_armed_r <= ctrl_nxt.rx_armed;
    end
  end

  assign powered = (out_phase_r == pps_pkg::PH_LOGIC) || (out_phase_r == pps_pkg::PH_FULL);
  assign full    = out_phase_r == pps_pkg::PH_FULL;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.rail_3v3_on     = powered;
  assign out_ch.rail_12v_on     = full;
  assign out_ch.link_enabled    = powered;
  assign out_ch.receive_armed   = out_armed_r;
  assign out_ch.power_phase     = out_phase_r;
  assign out_ch.color_send_ok   = full;
  assign out_ch.balance_send_ok = powered;

  `PPS_ASSERT(a_disabled_sticks, (ctrl_r.phase == pps_pkg::PH_DISABLED) |=> (ctrl_r.phase == pps_pkg::PH_DISABLED), "left disabled phase without reset")
  `PPS_ASSERT(a_armed_when_powered, ctrl_r.rx_armed |-> ((ctrl_r.phase == pps_pkg::PH_LOGIC) || (ctrl_r.phase == pps_pkg::PH_FULL)), "receive armed while unpowered")
  `PPS_ASSERT(a_result_tracks_state, in_fire |=> (out_valid_r && (out_phase_r == ctrl_r.phase) && (out_armed_r == ctrl_r.rx_armed)), "result word does not match state")
  `PPS_ASSERT_ALWAYS(a_empty_after_reset, $past(!rst_n) |-> !out_valid_r, "result valid right after reset")

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// self-checking testbench for panel_power_sequencer: directed rows, then random words
// over several register settings, then closing rows and noise; status words are checked
// against a model or the table; depends on pps_pkg, pps_if and the rtl top level
module tb_top;
  import pps_pkg::*;

  localparam int SAMPLE_BITS = 12;
  localparam int TICK_BITS   = 8;
  localparam int N_PHASES    = 8;
  localparam int PHASE_WORDS = 215;
  localparam int NOISE_WORDS = 40;
  localparam int N_LEAD      = 21;
  localparam int N_ROWS      = 26;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    logic [OP_W-1:0]        op;
    logic [SAMPLE_BITS-1:0] adc;
    logic [BYTE_W-1:0]      hb;
  } word_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               armed;
  } status_t;

  typedef struct packed {
    logic [OP_W-1:0]        op;
    logic [SAMPLE_BITS-1:0] adc;
    logic [BYTE_W-1:0]      hb;
    logic                   typed;
    logic [PHASE_W-1:0]     phase;
    logic                   armed;
  } row_t;

  // rows with typed = 0 are checked against the model
  row_t seq_table [N_ROWS] = '{
    '{OP_HEARTBEAT, 12'd0,    8'h80, 1'b1, PH_OFF,      1'b0},
    '{OP_POLL,      12'd4095, 8'h00, 1'b1, PH_OFF,      1'b0},
    '{OP_POLL,      12'd100,  8'h00, 1'b1, PH_OFF,      1'b0},
    '{OP_TICK,      12'd0,    8'h00, 1'b1, PH_OFF,      1'b0},
    '{OP_POLL,      12'd0,    8'h00, 1'b1, PH_LOGIC,    1'b1},
    '{OP_HEARTBEAT, 12'd0,    8'h8f, 1'b1, PH_LOGIC,    1'b1},
    '{OP_POLL,      12'd0,    8'h00, 1'b0, PH_OFF,      1'b0},
    '{OP_TICK,      12'd0,    8'h00, 1'b0, PH_OFF,      1'b0},
    '{OP_TICK,      12'd0,    8'h00, 1'b0, PH_OFF,      1'b0},
    '{OP_POLL,      12'd0,    8'h00, 1'b0, PH_OFF,      1'b0},
    '{OP_HEARTBEAT, 12'd0,    8'h70, 1'b0, PH_OFF,      1'b0},
    '{OP_HEARTBEAT, 12'd0,    8'h80, 1'b0, PH_OFF,      1'b0},
    '{OP_TICK,      12'd0,    8'h00, 1'b0, PH_OFF,      1'b0},
    '{OP_TICK,      12'd0,    8'h00, 1'b0, PH_OFF,      1'b0},
    '{OP_TICK,      12'd0,    8'h00, 1'b0, PH_OFF,      1'b0},
    '{OP_POLL,      12'd4095, 8'h00, 1'b0, PH_OFF,      1'b0},
    '{OP_POLL,      12'd99,   8'h00, 1'b0, PH_OFF,      1'b0},
    '{OP_HEARTBEAT, 12'd0,    8'hff, 1'b0, PH_OFF,      1'b0},
    '{OP_TICK,      12'd0,    8'h00, 1'b0, PH_OFF,      1'b0},
    '{OP_TICK,      12'd0,    8'h00, 1'b0, PH_OFF,      1'b0},
    '{OP_POLL,      12'd0,    8'h00, 1'b0, PH_OFF,      1'b0},
    // disable sticks until reset, so these rows run after the random phases
    '{OP_POLL,      12'd0,    8'h00, 1'b0, PH_OFF,      1'b0},
    '{OP_DISABLE,   12'hfff,  8'hff, 1'b1, PH_DISABLED, 1'b0},
    '{OP_POLL,      12'd0,    8'h00, 1'b1, PH_DISABLED, 1'b0},
    '{OP_HEARTBEAT, 12'd0,    8'h80, 1'b1, PH_DISABLED, 1'b0},
    '{OP_TICK,      12'd0,    8'h00, 1'b1, PH_DISABLED, 1'b0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pps_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  pps_out_if out_ch ();

  panel_power_sequencer #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .TICK_BITS  (TICK_BITS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // model of the sequencer
  cfg_t                 cfg_m;
  logic [PHASE_W-1:0]   ph_m;
  logic [TICK_BITS-1:0] ticks_m;
  logic                 alive_m;
  logic                 armed_m;

  status_t pending_status [$];
  int      n_words;
  int      n_results;
  int      n_full;
  int      n_settings;
  int      n_errors;
  int      burst_left;
  bit      no_idle;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout: status words still outstanding or input stuck");
    $display("TEST FAILED");
    $finish;
  end

  function automatic void power_off(input logic [PHASE_W-1:0] next_ph);
    ph_m    = next_ph;
    ticks_m = '0;
    alive_m = 1'b0;
    armed_m = 1'b0;
  endfunction

  function automatic status_t sequence_step(input word_t w);
    status_t s;
    case (w.op)
      OP_POLL: begin
        case (ph_m)
          PH_OFF: begin
            if (w.adc < cfg_m.threshold) begin
              ph_m    = PH_LOGIC;
              armed_m = 1'b1;
              ticks_m = '0;
            end
          end
          PH_LOGIC: begin
            if (ticks_m > cfg_m.hb_wait) begin
              if (alive_m) begin
                ph_m    = PH_FULL;
                ticks_m = '0;
                alive_m = 1'b0;
              end else begin
                power_off(PH_OFF);
              end
            end
          end
          PH_FULL: begin
            if (ticks_m > cfg_m.ka_wait) begin
              if (alive_m) begin
                ticks_m = '0;
                alive_m = 1'b0;
              end else begin
                power_off(PH_OFF);
              end
            end
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        if (ticks_m != '1) ticks_m = ticks_m + 1'b1;
      end
      OP_HEARTBEAT: begin
        // unarmed bytes are dropped; a wrong tag disarms until the next power-up
        if (armed_m) begin
          armed_m = 1'b0;
          if (ph_m != PH_OFF) begin
            alive_m = (w.hb[7:4] == cfg_m.hb_tag);
            armed_m = alive_m;
          end
        end
      end
      OP_DISABLE: power_off(PH_DISABLED);
      default: ;
    endcase
    s.phase = ph_m;
    s.armed = armed_m;
    return s;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 80) return 1;
    if (r < 95) return $urandom_range(2, 4);
    return $urandom_range(8, 20);
  endfunction

  // mostly power-up sequences with good heartbeats, plus tick bursts and noise
  function automatic word_t next_word();
    word_t w;
    int    r;
    w.adc = SAMPLE_BITS'($urandom);
    w.hb  = BYTE_W'($urandom);
    r     = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      w.op = OP_TICK;
    end else if (r < 2) begin
      burst_left = $urandom_range(1, 300);
      w.op = OP_TICK;
    end else if (ph_m == PH_OFF) begin
      if (r < 65) begin
        w.op = OP_POLL;
        if (cfg_m.threshold != '0 && r < 50)
          w.adc = SAMPLE_BITS'($urandom_range(0, int'(cfg_m.threshold) - 1));
      end else if (r < 85) begin
        w.op = OP_TICK;
      end else begin
        w.op = OP_HEARTBEAT;
      end
    end else begin
      if (r < 35) begin
        w.op = OP_TICK;
      end else if (r < 65) begin
        w.op = OP_POLL;
      end else begin
        w.op = OP_HEARTBEAT;
        if (r < 92) w.hb[7:4] = cfg_m.hb_tag;
      end
    end
    return w;
  endfunction

  function automatic cfg_t pick_cfg(input int k);
    cfg_t c;
    case (k)
      0: c = '{12'd4095, 8'd0, 8'd0, 4'd0};
      1: c = '{12'd0, 8'd255, 8'd255, 4'd15};
      2: c = '{12'd4095, 8'd255, 8'd255, 4'd15};
      default: begin
        c.threshold = THR_W'($urandom_range(1, 4095));
        c.hb_wait   = ($urandom_range(0, 3) == 0) ? WAIT_W'($urandom)
                                                  : WAIT_W'($urandom_range(0, 6));
        c.ka_wait   = ($urandom_range(0, 3) == 0) ? WAIT_W'($urandom)
                                                  : WAIT_W'($urandom_range(0, 6));
        c.hb_tag    = TAG_W'($urandom);
      end
    endcase
    return c;
  endfunction

  task automatic send_word(input word_t w, input logic typed, input status_t typed_st);
    int      gap;
    status_t st;
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid          <= 1'b1;
    in_ch.opcode         <= w.op;
    in_ch.adc_sample     <= w.adc;
    in_ch.heartbeat_byte <= w.hb;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    st = sequence_step(w);
    pending_status.push_back(typed ? typed_st : st);
    n_words++;
  endtask

  task automatic run_rows(input int first, input int last);
    word_t   w;
    status_t s;
    for (int i = first; i < last; i++) begin
      w.op    = seq_table[i].op;
      w.adc   = seq_table[i].adc;
      w.hb    = seq_table[i].hb;
      s.phase = seq_table[i].phase;
      s.armed = seq_table[i].armed;
      send_word(w, seq_table[i].typed, s);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apply_config(input cfg_t c);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_THRESHOLD;
    cfg_data  <= CFG_DATA_W'(c.threshold);
    @(negedge clk);
    cfg_index <= REG_HB_WAIT;
    cfg_data  <= CFG_DATA_W'(c.hb_wait);
    @(negedge clk);
    cfg_index <= REG_KA_WAIT;
    cfg_data  <= CFG_DATA_W'(c.ka_wait);
    @(negedge clk);
    cfg_index <= REG_HB_TAG;
    cfg_data  <= CFG_DATA_W'(c.hb_tag);
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_m = c;
    n_settings++;
  endtask

  function automatic logic is_powered(input logic [PHASE_W-1:0] ph);
    return (ph == PH_LOGIC) || (ph == PH_FULL);
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin
    status_t st;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (out_ch.power_phase == PH_FULL) n_full++;
      if (pending_status.size() == 0) begin
        $error("status word arrived with nothing expected");
        n_errors++;
      end else begin
        st = pending_status.pop_front();
        check_field("rail_3v3_on", is_powered(st.phase), out_ch.rail_3v3_on);
        check_field("rail_12v_on", st.phase == PH_FULL, out_ch.rail_12v_on);
        check_field("link_enabled", is_powered(st.phase), out_ch.link_enabled);
        check_field("receive_armed", st.armed, out_ch.receive_armed);
        check_field("power_phase", st.phase, out_ch.power_phase);
        check_field("color_send_ok", st.phase == PH_FULL, out_ch.color_send_ok);
        check_field("balance_send_ok", is_powered(st.phase), out_ch.balance_send_ok);
      end
    end
  end

  // receiver: random stalls, one long hold-off to back up the input
  initial begin
    int stall_left;
    bit held;
    stall_left = 0;
    held       = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (!held && n_results >= HOLD_AT) begin
        held       = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = idle_len();
      end
    end
  end

  initial begin
    word_t w;
    in_ch.valid          <= 1'b0;
    in_ch.opcode         <= OP_POLL;
    in_ch.adc_sample     <= '0;
    in_ch.heartbeat_byte <= '0;
    cfg_we               <= 1'b0;
    cfg_index            <= REG_THRESHOLD;
    cfg_data             <= '0;
    rst_n                <= 1'b0;
    n_words    = 0;
    n_results  = 0;
    n_full     = 0;
    n_settings = 0;
    n_errors   = 0;
    burst_left = 0;
    no_idle    = 1'b0;
    cfg_m      = '{THRESHOLD_RST, HB_WAIT_RST, KA_WAIT_RST, HB_TAG_RST};
    power_off(PH_OFF);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_rows(0, N_LEAD);

    for (int k = 0; k < N_PHASES; k++) begin
      drain();
      apply_config(pick_cfg(k));
      no_idle = (k == 3) || ($urandom_range(0, 4) == 0);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        w = next_word();
        send_word(w, 1'b0, '0);
      end
    end

    drain();
    no_idle = 1'b0;
    run_rows(N_LEAD, N_ROWS);
    // after disable: anything goes, the phase must stay disabled
    for (int i = 0; i < NOISE_WORDS; i++) begin
      w.op  = OP_W'($urandom);
      w.adc = SAMPLE_BITS'($urandom);
      w.hb  = BYTE_W'($urandom);
      send_word(w, 1'b0, '0);
    end
    drain();

    $display("sent %0d words under %0d register settings, checked %0d status words",
             n_words, n_settings + 1, n_results);
    $display("%0d status words at full power, %0d mismatches", n_full, n_errors);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ panel_power_sequencer.f @@
+incdir+rtl/core
rtl/core/pps_pkg.sv
rtl/core/pps_if.sv
rtl/core/pps_next.sv
rtl/core/panel_power_sequencer.sv
tb/sv/tb_top.sv
